// File: rtl/core/ssa_pkg.sv
// Shared widths, register indexes and controller command type for the slab slot allocator.
// No dependencies; imported by every module of the block.
package ssa_pkg;

  localparam int unsigned MAX_SLOTS = 1024;
  localparam int unsigned IDX_W     = 10;   // slot index width
  localparam int unsigned CNT_W     = 11;   // count width, holds MAX_SLOTS itself
  localparam int unsigned STRIDE_W  = 13;
  localparam int unsigned OFF_W     = 22;
  localparam int unsigned CFG_W     = 13;   // widest configuration register
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0]    CNT_MAX       = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0]    SLOTS_LIMIT   = CNT_W'(MAX_SLOTS);
  localparam logic [CNT_W-1:0]    COUNT_RESET   = CNT_W'(1024);
  localparam logic [STRIDE_W-1:0] STRIDE_RESET  = STRIDE_W'(8);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_STRIDE = 1'b1;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic load;    // capture the request beat
    logic commit;  // update allocator state and load the result register
  } ssa_cmd_t;

endpackage

// File: rtl/core/slab_slot_allocator.sv
// Slab slot allocator: a request has a capture step to take the beat and an update step to
// update the free list and bump counter and load the result register. The pace is set by
// the free-list link memory: its registered read must follow the head written by the
// previous request before a pop can use it. A new request is taken while a result waits;
// it then holds in the update step until the waiting result beat is taken. No clearing
// pass after reset; the link memory is read only where it was written.
module slab_slot_allocator import ssa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_kind,
  input  logic [IDX_W-1:0]     in_slot_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_ok,
  output logic [IDX_W-1:0]     out_granted_slot,
  output logic [OFF_W-1:0]     out_byte_offset,
  output logic                 out_full_res,
  output logic                 out_empty_res
);

  ssa_cmd_t cmd;

  ssa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ssa_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_kind          (in_kind),
    .in_slot_index    (in_slot_index),
    .out_ok           (out_ok),
    .out_granted_slot (out_granted_slot),
    .out_byte_offset  (out_byte_offset),
    .out_full_res     (out_full_res),
    .out_empty_res    (out_empty_res)
  );

endmodule

// File: rtl/core/ssa_ctrl.sv
// Controller FSM of the slab slot allocator: input/output handshake and sequencing.
// Depends on ssa_pkg (command struct).
module ssa_ctrl import ssa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output ssa_cmd_t cmd
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.load   = (state_r == S_IDLE) && in_valid;
  assign cmd.commit = (state_r == S_EXEC) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_EXEC;
        end
        S_EXEC: begin
          // wait here while the previous result is still held
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase

      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/ssa_dpath.sv
// Datapath of the slab slot allocator: config registers, free-list link memory,
// bump/list counters, offset multiplier and result register. Depends on ssa_pkg.
module ssa_dpath import ssa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ssa_cmd_t             cmd,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_kind,
  input  logic [IDX_W-1:0]     in_slot_index,
  output logic                 out_ok,
  output logic [IDX_W-1:0]     out_granted_slot,
  output logic [OFF_W-1:0]     out_byte_offset,
  output logic                 out_full_res,
  output logic                 out_empty_res
);

  logic [CNT_W-1:0]    slot_count_r;
  logic [STRIDE_W-1:0] slot_stride_r;

  logic                req_kind_r;
  logic [IDX_W-1:0]    req_idx_r;

  logic [IDX_W-1:0]    list_head_r, list_head_nxt;
  logic [CNT_W-1:0]    list_count_r, list_count_nxt;
  logic [CNT_W-1:0]    bump_count_r, bump_count_nxt;

  // free-list links; rd_link_r is a registered read of mem[list_head_r]
  logic [IDX_W-1:0]    next_free_mem [MAX_SLOTS];
  logic [IDX_W-1:0]    rd_link_r;

  logic [CNT_W-1:0]    eff_count;
  logic                ok;
  logic [IDX_W-1:0]    slot;
  logic                push;
  logic                free_hit_bump;
  logic [IDX_W+STRIDE_W-1:0] product;

  logic                ok_r;
  logic [IDX_W-1:0]    granted_r;
  logic [OFF_W-1:0]    offset_r;
  logic                full_r;
  logic                empty_r;

  assign eff_count = (slot_count_r > SLOTS_LIMIT) ? SLOTS_LIMIT : slot_count_r;

  // freeing the most recently bumped slot just winds the bump counter back
  assign free_hit_bump = (bump_count_r != '0) &&
                         ({1'b0, req_idx_r} == (bump_count_r - CNT_W'(1)));

  always_comb begin
    ok             = 1'b0;
    slot           = '0;
    push           = 1'b0;
    list_head_nxt  = list_head_r;
    list_count_nxt = list_count_r;
    bump_count_nxt = bump_count_r;
    if (req_kind_r == KIND_ALLOC) begin
      if (list_count_r != '0) begin
        ok             = 1'b1;
        slot           = list_head_r;
        list_head_nxt  = rd_link_r;
        list_count_nxt = list_count_r - CNT_W'(1);
      end else if (bump_count_r < eff_count) begin
        ok             = 1'b1;
        slot           = bump_count_r[IDX_W-1:0];
        bump_count_nxt = bump_count_r + CNT_W'(1);
      end
    end else if ({1'b0, req_idx_r} < eff_count) begin
      ok = 1'b1;
      if (free_hit_bump) begin
        bump_count_nxt = bump_count_r - CNT_W'(1);
      end else begin
        push          = 1'b1;
        list_head_nxt = req_idx_r;
        if (list_count_r != CNT_MAX) list_count_nxt = list_count_r + CNT_W'(1);
      end
    end
  end

  assign product = {{STRIDE_W{1'b0}}, slot} * {{IDX_W{1'b0}}, slot_stride_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r  <= COUNT_RESET;
      slot_stride_r <= STRIDE_RESET;
      list_head_r   <= '0;
      list_count_r  <= '0;
      bump_count_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SLOT_COUNT:  slot_count_r  <= cfg_wdata[CNT_W-1:0];
          REG_SLOT_STRIDE: slot_stride_r <= cfg_wdata[STRIDE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        list_head_r  <= list_head_nxt;
        list_count_r <= list_count_nxt;
        bump_count_r <= bump_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && push) next_free_mem[req_idx_r] <= list_head_r;
    rd_link_r <= next_free_mem[list_head_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind_r <= in_kind;
      req_idx_r  <= in_slot_index;
    end
    if (cmd.commit) begin
      ok_r      <= ok;
      granted_r <= slot;
      offset_r  <= product[OFF_W-1:0];
      full_r    <= (bump_count_nxt >= eff_count) && (list_count_nxt == '0);
      empty_r   <= (bump_count_nxt == list_count_nxt);
    end
  end

  assign out_ok           = ok_r;
  assign out_granted_slot = granted_r;
  assign out_byte_offset  = offset_r;
  assign out_full_res     = full_r;
  assign out_empty_res    = empty_r;

endmodule

// File: rtl/core/ssa_checker.sv
// Port-level checker for the slab slot allocator, bound onto the top level.
// Depends on ssa_pkg for widths.
module ssa_checker import ssa_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_ok,
  input logic [IDX_W-1:0] out_granted_slot,
  input logic [OFF_W-1:0] out_byte_offset,
  input logic             out_full_res,
  input logic             out_empty_res
);

  // a held result beat keeps every field
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ok) && $stable(out_granted_slot)
      && $stable(out_byte_offset) && $stable(out_full_res) && $stable(out_empty_res))
    else $error("result beat changed while stalled");

  // one request in flight: busy right after a beat is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in flight");

  // a failed request grants nothing
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_granted_slot == '0 && out_byte_offset == '0)
    else $error("failed request carries a slot or offset");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind slab_slot_allocator ssa_checker u_ssa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_ok           (out_ok),
  .out_granted_slot (out_granted_slot),
  .out_byte_offset  (out_byte_offset),
  .out_full_res     (out_full_res),
  .out_empty_res    (out_empty_res)
);
